[src/edge_timed_uart_receiver_fifo_assert.svh]
// Assertion macros used by the checker file.
// All of them sample on posedge clk and are off while rst_n is low.
`ifndef EDGE_TIMED_UART_RECEIVER_FIFO_ASSERT_SVH
`define EDGE_TIMED_UART_RECEIVER_FIFO_ASSERT_SVH

// ante true -> cons true in the same cycle
`define ETUR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// ante true -> cons true in the next cycle
`define ETUR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/etur_pkg.sv]
`default_nettype none
package etur_pkg;

  localparam int BIT_TIME_W = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int BYTE_BITS  = 8;
  localparam int LATE_BITS  = 9;

  localparam logic [BIT_TIME_W-1:0] BIT_TIME_RESET = 20'd8333;

  localparam logic [CFG_IDX_W-1:0] CFG_BIT_TIME    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_LINE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RX_ENABLE   = 2'd2;

  localparam logic [1:0] CMD_EDGE  = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_FLUSH = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] edge_time;
    logic        line_level;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       read_valid;
    logic [7:0] head_data;
    logic [5:0] fifo_count;
    logic       overflow_flag;
    logic       byte_done;
  } out_item_t;

endpackage
`default_nettype wire

[src/edge_timed_uart_receiver_fifo.sv]
// Edge-timed 8N1 UART receiver with a byte FIFO.
// Input channel (in_valid/in_stall/in_item): one command per item. An edge
// event carries the cycle count of a line edge and the line level after it;
// pop, flush and clear-overflow commands act on the FIFO and the sticky flag.
// Output channel (out_valid/out_stall/out_item): exactly one result per item,
// in order, with the popped byte, the FIFO head and count, the overflow flag
// and a byte-done mark.
// Config port: cfg_we writes cfg_wdata into register cfg_idx (0 bit_time,
// 1 invert_line, 2 rx_enable); write only while no item is in flight.
// Sequencing: an edge event with the receiver enabled first waits in S_DIV
// for the two bit-serial dividers that turn elapsed time into bit counts;
// every item then passes S_APPLY, S_RD and S_FIN before its result is loaded.
// One item is worked on at a time, so the next item can be taken in the cycle
// after the result is loaded, and a finished result waits in S_FIN while the
// output side stalls an earlier result still held in the output register.
// in_stall is low only while the block is ready for a new item.
// Bytes are kept in a FIFO_DEPTH-entry RAM (FIFO_DEPTH-1 usable, one read
// port with registered data); pointers and decoder state reset to empty and
// idle, the RAM itself is not cleared.
`default_nettype none
module edge_timed_uart_receiver_fifo #(
  parameter int FIFO_DEPTH = 64,
  parameter int TIME_BITS  = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire etur_pkg::in_item_t                in_item,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output etur_pkg::out_item_t                    out_item,
  input  wire logic                              cfg_we,
  input  wire logic [etur_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire logic [etur_pkg::BIT_TIME_W-1:0]   cfg_wdata
);
  import etur_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_APPLY = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_START = 2'd1;
  localparam logic [1:0] PH_READ  = 2'd2;

  typedef struct packed {
    logic [7:0] sb;
    logic [3:0] bc;
    logic       full;
  } shift_res_t;

  // shift n copies of lvl in from the top, stop once 8 bits are held
  function automatic shift_res_t do_shift(input logic [7:0] sb, input logic [3:0] bc,
                                          input logic lvl, input logic [3:0] n);
    shift_res_t res;
    logic [3:0] room;
    logic [3:0] k;
    logic [4:0] idx;
    room = 4'(BYTE_BITS) - bc;
    k    = (n < room) ? n : room;
    for (int j = 0; j < BYTE_BITS; j++) begin
      idx       = 5'(j) + {1'b0, k};
      res.sb[j] = (idx >= 5'(BYTE_BITS)) ? lvl : sb[idx[2:0]];
    end
    res.bc   = bc + k;
    res.full = (k != 4'd0) && (res.bc == 4'(BYTE_BITS));
    return res;
  endfunction

  function automatic logic [3:0] cap8(input logic [TIME_BITS:0] v);
    return (v >= (TIME_BITS+1)'(BYTE_BITS)) ? 4'(BYTE_BITS) : v[3:0];
  endfunction

  // config
  logic [BIT_TIME_W-1:0] bit_time_r;
  logic                  invert_r;
  logic                  rx_en_r;

  // sequencer and item
  logic [2:0]           state_r, state_nxt;
  logic [1:0]           cmd_r;
  logic                 lvl_raw_r;
  logic [TIME_BITS-1:0] t_r;

  // decoder
  logic [1:0]           phase_r, phase_nxt;
  logic [TIME_BITS-1:0] byte_start_r, byte_start_nxt;
  logic [TIME_BITS-1:0] pulse_start_r, pulse_start_nxt;
  logic [7:0]           shift_r, shift_nxt;
  logic [3:0]           bc_r, bc_nxt;

  // fifo
  logic [7:0]       mem [FIFO_DEPTH];
  logic [7:0]       mem_q;
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic             ovf_r, ovf_nxt;
  logic             wr_en;
  logic [7:0]       wr_data;
  logic [PTR_W-1:0] wptr_inc, rptr_inc;
  logic             nonempty;

  // per-item results
  logic       rd_valid_r, rd_valid_nxt;
  logic [7:0] rd_byte_r, rd_byte_nxt;
  logic       done_r, done_nxt;

  // output register
  logic      out_valid_r;
  out_item_t out_r;
  logic      out_load;

  // dividers
  logic                 accept;
  logic                 div_start;
  logic [TIME_BITS-1:0] t_in;
  logic                 pulse_done, whole_done;
  logic [TIME_BITS:0]   pulse_q, whole_q, pulse_m1;

  logic       level, lvl_prev;
  shift_res_t sr;
  logic       push_req;
  logic [7:0] push_byte;
  logic [PTR_W:0] count_full;

  assign accept    = in_valid && (state_r == S_IDLE);
  assign in_stall  = (state_r != S_IDLE);
  assign t_in      = TIME_BITS'(in_item.edge_time);
  assign div_start = accept && (in_item.cmd == CMD_EDGE) && rx_en_r;

  etur_div #(.DIVIDEND_W(TIME_BITS)) u_div_pulse (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (t_in - pulse_start_r),
    .divisor   (bit_time_r),
    .done      (pulse_done),
    .quo_round (pulse_q)
  );

  etur_div #(.DIVIDEND_W(TIME_BITS)) u_div_whole (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (t_in - byte_start_r),
    .divisor   (bit_time_r),
    .done      (whole_done),
    .quo_round (whole_q)
  );

  assign wptr_inc = (wptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
  assign rptr_inc = (rptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
  assign nonempty = (wptr_r != rptr_r);

  // decode and fifo update for the item; committed in S_APPLY
  always_comb begin
    level           = lvl_raw_r ^ invert_r;
    lvl_prev        = ~level;
    pulse_m1        = (pulse_q == '0) ? '0 : pulse_q - 1'b1;
    sr              = '0;
    push_req        = 1'b0;
    push_byte       = shift_r;
    phase_nxt       = phase_r;
    byte_start_nxt  = byte_start_r;
    pulse_start_nxt = pulse_start_r;
    shift_nxt       = shift_r;
    bc_nxt          = bc_r;
    wptr_nxt        = wptr_r;
    rptr_nxt        = rptr_r;
    ovf_nxt         = ovf_r;
    rd_valid_nxt    = 1'b0;
    rd_byte_nxt     = 8'd0;
    done_nxt        = 1'b0;
    wr_en           = 1'b0;
    wr_data         = shift_r;

    case (cmd_r)
      CMD_EDGE: begin
        if (rx_en_r) begin
          case (phase_r)
            PH_START: begin
              // first pulse includes the start bit
              sr        = do_shift(shift_r, bc_r, lvl_prev, cap8(pulse_m1));
              shift_nxt = sr.sb;
              bc_nxt    = sr.bc;
              if (sr.full) begin
                push_req  = 1'b1;
                push_byte = sr.sb;
                phase_nxt = PH_IDLE;
                done_nxt  = 1'b1;
              end else begin
                pulse_start_nxt = t_r;
                phase_nxt       = PH_READ;
              end
            end
            PH_READ: begin
              pulse_start_nxt = t_r;
              if (whole_q > (TIME_BITS+1)'(LATE_BITS)) begin
                // late edge: pad with stop-level ones, this edge opens a new byte
                sr             = do_shift(shift_r, bc_r, 1'b1, 4'(BYTE_BITS));
                push_req       = 1'b1;
                push_byte      = sr.sb;
                byte_start_nxt = t_r;
                shift_nxt      = 8'd0;
                bc_nxt         = 4'd0;
                phase_nxt      = PH_START;
                done_nxt       = 1'b1;
              end else begin
                sr        = do_shift(shift_r, bc_r, lvl_prev, cap8(pulse_q));
                shift_nxt = sr.sb;
                bc_nxt    = sr.bc;
                if (sr.full) begin
                  push_req  = 1'b1;
                  push_byte = sr.sb;
                  phase_nxt = PH_IDLE;
                  done_nxt  = 1'b1;
                end
              end
            end
            default: begin
              if (!level) begin
                byte_start_nxt  = t_r;
                pulse_start_nxt = t_r;
                shift_nxt       = 8'd0;
                bc_nxt          = 4'd0;
                phase_nxt       = PH_START;
              end
            end
          endcase
        end
      end
      CMD_POP: begin
        if (nonempty) begin
          rd_valid_nxt = 1'b1;
          rd_byte_nxt  = mem_q;
          rptr_nxt     = rptr_inc;
        end
      end
      CMD_FLUSH: begin
        wptr_nxt = '0;
        rptr_nxt = '0;
      end
      default: begin
        ovf_nxt = 1'b0;
      end
    endcase

    if (push_req) begin
      if (wptr_inc != rptr_r) begin
        wr_en    = (state_r == S_APPLY);
        wr_data  = push_byte;
        wptr_nxt = wptr_inc;
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  // head entry is read back in S_RD, after any write in S_APPLY, and mem_q then
  // holds it until the next step, where a pop takes it
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wptr_r] <= wr_data;
    end
    if (state_r == S_RD) begin
      mem_q <= mem[rptr_r];
    end
  end

  assign out_load = (state_r == S_FIN) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = div_start ? S_DIV : S_APPLY;
        end
      end
      S_DIV: begin
        if (pulse_done && whole_done) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: state_nxt = S_RD;
      S_RD:    state_nxt = S_FIN;
      S_FIN: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      bit_time_r    <= BIT_TIME_RESET;
      invert_r      <= 1'b0;
      rx_en_r       <= 1'b1;
      phase_r       <= PH_IDLE;
      byte_start_r  <= '0;
      pulse_start_r <= '0;
      shift_r       <= 8'd0;
      bc_r          <= 4'd0;
      wptr_r        <= '0;
      rptr_r        <= '0;
      ovf_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_BIT_TIME:    bit_time_r <= cfg_wdata;
          CFG_INVERT_LINE: invert_r   <= cfg_wdata[0];
          CFG_RX_ENABLE:   rx_en_r    <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (state_r == S_APPLY) begin
        phase_r       <= phase_nxt;
        byte_start_r  <= byte_start_nxt;
        pulse_start_r <= pulse_start_nxt;
        shift_r       <= shift_nxt;
        bc_r          <= bc_nxt;
        wptr_r        <= wptr_nxt;
        rptr_r        <= rptr_nxt;
        ovf_r         <= ovf_nxt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r     <= in_item.cmd;
      lvl_raw_r <= in_item.line_level;
      t_r       <= t_in;
    end
    if (state_r == S_APPLY) begin
      rd_valid_r <= rd_valid_nxt;
      rd_byte_r  <= rd_byte_nxt;
      done_r     <= done_nxt;
    end
  end

  assign count_full = (wptr_r >= rptr_r) ? {1'b0, wptr_r} - {1'b0, rptr_r}
                    : {1'b0, wptr_r} + (PTR_W+1)'(FIFO_DEPTH) - {1'b0, rptr_r};

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.read_data     <= rd_byte_r;
      out_r.read_valid    <= rd_valid_r;
      out_r.head_data     <= nonempty ? mem_q : 8'd0;
      out_r.fifo_count    <= 6'(count_full);
      out_r.overflow_flag <= ovf_r;
      out_r.byte_done     <= done_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
`default_nettype wire

[src/etur_div.sv]
`default_nettype none
// Restoring divider, one quotient bit per cycle, result rounded half up.
module etur_div #(
  parameter int DIVIDEND_W = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  input  wire logic [DIVIDEND_W-1:0]               dividend,
  input  wire logic [etur_pkg::BIT_TIME_W-1:0]     divisor,
  output logic                                     done,
  output logic [DIVIDEND_W:0]                      quo_round
);
  import etur_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_r;
  logic                  done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [BIT_TIME_W-1:0] rem_r;
  logic [BIT_TIME_W-1:0] dvs_r;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIVIDEND_W:0]   qr_r;

  logic [BIT_TIME_W:0]   sh;
  logic                  ge;
  logic [BIT_TIME_W-1:0] rem_nxt;
  logic                  round_up;

  always_comb begin
    sh       = {rem_r, quo_r[DIVIDEND_W-1]};
    ge       = (sh >= {1'b0, dvs_r});
    rem_nxt  = ge ? BIT_TIME_W'(sh - {1'b0, dvs_r}) : sh[BIT_TIME_W-1:0];
    // remainder at least half the divisor rounds up
    round_up = ({rem_r, 1'b0} >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIVIDEND_W);
      end else if (busy_r) begin
        if (cnt_r != '0) begin
          cnt_r <= cnt_r - 1'b1;
        end else begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= (divisor == '0) ? BIT_TIME_W'(1) : divisor;
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[DIVIDEND_W-2:0], ge};
      end else begin
        qr_r <= {1'b0, quo_r} + (DIVIDEND_W+1)'(round_up);
      end
    end
  end

  assign done      = done_r;
  assign quo_round = qr_r;

endmodule
`default_nettype wire

[src/etur_checker.sv]
`default_nettype none
`include "edge_timed_uart_receiver_fifo_assert.svh"
module etur_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire etur_pkg::in_item_t   in_item,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire etur_pkg::out_item_t  out_item
);
  import etur_pkg::*;

  // one item in flight: taking an item closes the input until its result is made
  `ETUR_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall, "second item taken while busy")

  // a result waiting on a stalled receiver is held
  `ETUR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item), "stalled result changed")

  // read_data is zero unless a pop returned a byte
  `ETUR_ASSERT_SAME(a_rd_zero, out_valid && !out_item.read_valid, out_item.read_data == 8'd0, "read_data set without read_valid")

  // a pop never also completes a received byte
  `ETUR_ASSERT_SAME(a_pop_edge, out_valid && out_item.read_valid, !out_item.byte_done, "byte_done on a pop result")

endmodule

bind edge_timed_uart_receiver_fifo etur_checker u_etur_checker (.*);
`default_nettype wire

[sim/edge_timed_uart_receiver_fifo_test.sv]
`default_nettype none
module edge_timed_uart_receiver_fifo_test;
  import etur_pkg::*;

  localparam int ITEM_TARGET = 1350;
  localparam int QUIET_ITEMS = 200;

  typedef enum logic [1:0] {
    PH_WAIT_START,
    PH_GOT_START,
    PH_READING
  } rx_phase_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [BIT_TIME_W-1:0] cfg_wdata = '0;

  edge_timed_uart_receiver_fifo u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // decoder and fifo mirror, reset values
  logic [BIT_TIME_W-1:0] bt_reg = BIT_TIME_RESET;
  logic inv_reg = 1'b0;
  logic rxen_reg = 1'b1;
  rx_phase_e ph = PH_WAIT_START;
  logic [31:0] byte_t0 = '0;
  logic [31:0] pulse_t0 = '0;
  logic [7:0] sh_byte = '0;
  int unsigned sh_cnt = 0;
  logic [7:0] fifo_mem [64];
  logic [5:0] wr_ptr = '0;
  logic [5:0] rd_ptr = '0;
  logic ovf_seen = 1'b0;

  out_item_t status_due [$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  bit quiet = 1'b0;
  int hold_req = 0;
  int hold_left = 0;
  int stall_left = 0;
  logic [31:0] line_t = '0;

  function automatic longint unsigned bits_in(input logic [31:0] dt);
    longint unsigned d;
    longint unsigned q;
    longint unsigned r;
    d = (bt_reg == 0) ? 1 : bt_reg;
    q = dt / d;
    r = dt % d;
    return q + ((r >= d - r) ? 1 : 0);
  endfunction

  function automatic logic shift_bits(input logic lvl, input longint unsigned n);
    longint unsigned k;
    logic full;
    k = n;
    full = 1'b0;
    while (k != 0 && sh_cnt < BYTE_BITS) begin
      sh_byte = {lvl, sh_byte[7:1]};
      sh_cnt++;
      k--;
      if (sh_cnt == BYTE_BITS) full = 1'b1;
    end
    return full;
  endfunction

  function automatic void store_byte();
    if (wr_ptr + 6'd1 != rd_ptr) begin
      fifo_mem[wr_ptr] = sh_byte;
      wr_ptr++;
    end else begin
      ovf_seen = 1'b1;
    end
  endfunction

  function automatic void start_byte(input logic [31:0] t);
    byte_t0 = t;
    pulse_t0 = t;
    sh_byte = '0;
    sh_cnt = 0;
    ph = PH_GOT_START;
  endfunction

  function automatic logic line_edge(input logic [31:0] t, input logic raw);
    logic lvl;
    logic done;
    longint unsigned pulse;
    longint unsigned whole;
    lvl = raw ^ inv_reg;
    pulse = bits_in(t - pulse_t0);
    whole = bits_in(t - byte_t0);
    done = 1'b0;
    case (ph)
      PH_GOT_START: begin
        // first pulse still holds the start bit
        if (shift_bits(~lvl, (pulse == 0) ? 0 : pulse - 1)) begin
          store_byte();
          ph = PH_WAIT_START;
          done = 1'b1;
        end else begin
          pulse_t0 = t;
          ph = PH_READING;
        end
      end
      PH_READING: begin
        if (whole > LATE_BITS) begin
          // missing bits are stop-level ones; this edge opens a new byte
          void'(shift_bits(1'b1, BYTE_BITS));
          store_byte();
          start_byte(t);
          done = 1'b1;
        end else if (shift_bits(~lvl, pulse)) begin
          store_byte();
          ph = PH_WAIT_START;
          done = 1'b1;
        end
        pulse_t0 = t;
      end
      default: if (!lvl) start_byte(t);
    endcase
    return done;
  endfunction

  function automatic out_item_t rx_fifo_step(input in_item_t it);
    out_item_t r;
    r = '0;
    case (it.cmd)
      CMD_EDGE: if (rxen_reg) r.byte_done = line_edge(it.edge_time, it.line_level);
      CMD_POP: begin
        if (wr_ptr != rd_ptr) begin
          r.read_data = fifo_mem[rd_ptr];
          r.read_valid = 1'b1;
          rd_ptr++;
        end
      end
      CMD_FLUSH: begin
        wr_ptr = '0;
        rd_ptr = '0;
      end
      CMD_CLEAR: ovf_seen = 1'b0;
      default: ;
    endcase
    if (wr_ptr != rd_ptr) r.head_data = fifo_mem[rd_ptr];
    r.fifo_count = wr_ptr - rd_ptr;
    r.overflow_flag = ovf_seen;
    return r;
  endfunction

  task automatic report(input string what, input longint unsigned got,
                        input longint unsigned want);
    errors++;
    // keep the log short when the block is badly broken
    if (errors <= 100)
      $display("mismatch at result %0d: %s got %0h want %0h", results_seen, what, got, want);
  endtask

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (status_due.size() == 0) begin
        report("unexpected result", out_item, 0);
      end else begin
        want = status_due.pop_front();
        if (out_item.read_data !== want.read_data)
          report("read_data", out_item.read_data, want.read_data);
        if (out_item.read_valid !== want.read_valid)
          report("read_valid", out_item.read_valid, want.read_valid);
        if (out_item.head_data !== want.head_data)
          report("head_data", out_item.head_data, want.head_data);
        if (out_item.fifo_count !== want.fifo_count)
          report("fifo_count", out_item.fifo_count, want.fifo_count);
        if (out_item.overflow_flag !== want.overflow_flag)
          report("overflow_flag", out_item.overflow_flag, want.overflow_flag);
        if (out_item.byte_done !== want.byte_done)
          report("byte_done", out_item.byte_done, want.byte_done);
      end
      results_seen++;
    end
  end

  // receiver side: random short stalls, plus one long hold on request
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_item(input in_item_t it);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    status_due.push_back(rx_fifo_step(it));
    items_sent++;
  endtask

  task automatic send_edge(input logic [31:0] t, input logic lvl);
    in_item_t it;
    it.cmd = CMD_EDGE;
    it.edge_time = t;
    it.line_level = lvl ^ inv_reg;
    send_item(it);
  endtask

  task automatic send_cmd(input logic [1:0] cmd);
    in_item_t it;
    it.cmd = cmd;
    it.edge_time = $urandom;
    it.line_level = 1'($urandom);
    send_item(it);
  endtask

  // one 8N1 character starting at line_t; edges only where the level changes
  task automatic send_frame(input logic [7:0] data, input int unsigned idle_bits);
    logic [9:0] bits;
    logic prev;
    int unsigned k;
    int unsigned bt;
    int jit;
    bits = {1'b1, data, 1'b0};
    bt = (bt_reg == 0) ? 1 : bt_reg;
    prev = 1'b1;
    for (k = 0; k < 10; k++) begin
      if (bits[k] != prev) begin
        jit = (k == 0 || bt < 8) ? 0 : int'($urandom_range(0, bt / 2)) - int'(bt / 4);
        send_edge(line_t + k * bt + jit, bits[k]);
        prev = bits[k];
      end
    end
    line_t = line_t + (10 + idle_bits) * bt;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_config(input logic [BIT_TIME_W-1:0] bt, input logic inv,
                            input logic en);
    logic [BIT_TIME_W-2:0] junk;
    wait_idle();
    junk = (BIT_TIME_W-1)'($urandom);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_BIT_TIME;
    cfg_wdata <= bt;
    @(posedge clk);
    cfg_idx <= CFG_INVERT_LINE;
    cfg_wdata <= {junk, inv};
    @(posedge clk);
    cfg_idx <= CFG_RX_ENABLE;
    cfg_wdata <= {~junk, en};
    @(posedge clk);
    cfg_we <= 1'b0;
    bt_reg = bt;
    inv_reg = inv;
    rxen_reg = en;
  endtask

  task automatic test_directed();
    set_config(20'd16, 1'b0, 1'b1);
    line_t = 32'd1000;
    send_cmd(CMD_POP);
    send_cmd(CMD_CLEAR);
    send_cmd(CMD_FLUSH);
    send_frame(8'h00, 0);
    send_frame(8'hFF, 1);
    send_frame(8'h80, 0);
    send_frame(8'h01, 0);
    send_edge(line_t, 1'b1);                 // rising edge while waiting: ignored
    send_edge(line_t + 32'd40, 1'b0);
    send_edge(line_t + 32'd43, 1'b1);        // glitch shorter than half a bit
    line_t = line_t + 32'd40 + 32'd12 * 16;
    send_edge(line_t, 1'b1);                 // late edge, restarts although high
    send_cmd(CMD_POP);
    send_edge(32'hFFFF_FFFF, 1'b1);
    line_t = 32'hFFFF_FFC0;                  // character straddles the counter wrap
    send_frame(8'h0F, 0);
    send_edge(32'd0, 1'b1);
    send_cmd(CMD_POP);
    send_cmd(CMD_POP);
    send_cmd(CMD_FLUSH);
    send_cmd(CMD_POP);
  endtask

  task automatic test_settings_sweep();
    logic [BIT_TIME_W-1:0] bts [5];
    logic invs [5];
    logic ens [5];
    int i;
    int j;
    bts = '{20'd16, 20'hFFFFF, 20'd0, BIT_TIME_RESET, 20'd8333};
    invs = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
    ens = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
    for (i = 0; i < 5; i++) begin
      set_config(bts[i], invs[i], ens[i]);
      line_t = $urandom;
      for (j = 0; j < 6; j++) begin
        send_frame(8'($urandom), $urandom_range(0, 2));
        if ($urandom_range(0, 1) == 0) send_cmd(CMD_POP);
      end
      send_cmd(CMD_POP);
      send_cmd(CMD_POP);
    end
  endtask

  task automatic test_fifo_overflow();
    logic [7:0] fills [4];
    int i;
    fills = '{8'hFF, 8'h00, 8'h7F, 8'hFE};
    set_config(BIT_TIME_W'($urandom_range(16, 40)), 1'b0, 1'b1);
    send_cmd(CMD_FLUSH);
    line_t = $urandom;
    for (i = 0; i < 68; i++)
      send_frame(($urandom_range(0, 7) == 0) ? 8'($urandom) : fills[$urandom_range(0, 3)], 0);
    send_cmd(CMD_POP);
    send_cmd(CMD_FLUSH);                     // flag survives a flush
    send_cmd(CMD_POP);
    send_cmd(CMD_CLEAR);
  endtask

  task automatic test_output_backpressure();
    int i;
    set_config(BIT_TIME_W'($urandom_range(16, 64)), 1'b0, 1'b1);
    line_t = $urandom;
    hold_req = 300;
    for (i = 0; i < 15; i++) begin
      send_frame(8'($urandom), 0);
      send_cmd(CMD_POP);
    end
  endtask

  task automatic test_random_traffic();
    int next_cfg_at;
    int op;
    int n;
    int unsigned bt;
    logic [BIT_TIME_W-1:0] bt_pick;
    next_cfg_at = items_sent;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= next_cfg_at) begin
        op = $urandom_range(0, 5);
        bt_pick = (op == 0) ? BIT_TIME_W'($urandom_range(16, 20'hFFFFF)) :
                  (op == 1) ? BIT_TIME_RESET : BIT_TIME_W'($urandom_range(16, 64));
        set_config(bt_pick, 1'($urandom), $urandom_range(0, 5) != 0);
        line_t = $urandom;
        next_cfg_at = items_sent + 250;
      end
      quiet = (items_sent >= ITEM_TARGET - QUIET_ITEMS);
      bt = (bt_reg == 0) ? 1 : bt_reg;
      op = $urandom_range(0, 99);
      if (op < 45) begin
        send_frame(8'($urandom), $urandom_range(0, 3));
      end else if (op < 77) begin
        send_cmd(CMD_POP);
      end else if (op < 83) begin
        // start bit followed by a few edges at random spacing
        send_edge(line_t, 1'b0);
        for (n = $urandom_range(1, 3); n > 0; n--)
          send_edge(line_t + $urandom_range(0, 12 * bt), 1'($urandom));
        line_t = line_t + 14 * bt;
      end else if (op < 91) begin
        if ($urandom_range(0, 3) == 0) line_t = $urandom;
        else line_t = line_t + $urandom_range(0, 3 * bt);
        send_edge(line_t, 1'($urandom));
      end else if (op < 95) begin
        send_cmd(CMD_FLUSH);
      end else begin
        send_cmd(CMD_CLEAR);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_settings_sweep();
    test_fifo_overflow();
    test_output_backpressure();
    test_random_traffic();
    wait_idle();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
`default_nettype wire
